// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked, and disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg
// types and constants of the rectangle canvas raster
// ----------------------------------------------------------------------------
package rcr_pkg;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SIZE = 2'd1;
    localparam logic [1:0] STAT_KIND = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    localparam logic [7:0] KIND_OUTLINE = 8'h72;
    localparam logic [7:0] KIND_FILLED  = 8'h52;

    localparam int FRAC_BITS = 8;
    // room for a 24-bit edge plus a 24-bit size, and for a 12-bit pixel index in Q.8
    localparam int CW = 27;
    localparam logic signed [CW-1:0] FRAC_ONE = 27'sd256;

    localparam logic [7:0] BG_RESET = 8'h20;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [23:0] rect_x;
        logic signed [23:0] rect_y;
        logic signed [23:0] rect_w;
        logic signed [23:0] rect_h;
        logic [7:0]         rect_kind;
        logic [7:0]         paint_char;
        logic [8:0]         pixel_col;
        logic [8:0]         pixel_row;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [1:0] status;
    } t_out;

    typedef enum logic [1:0] {
        RT_SCAN,
        RT_READ,
        RT_DONE
    } t_route;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_RDATA,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_route route;
        logic   scan_last;
    } t_dp_sts;

endpackage

// ===== sv/rcr_datapath.sv =====
// ----------------------------------------------------------------------------
// rcr_datapath
// canvas memory, configuration registers, scan counters and pixel test
// ----------------------------------------------------------------------------
module rcr_datapath import rcr_pkg::*; #(
    parameter int MAX_SIDE = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    input  t_in         i_in,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output t_out        o_out
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW     = $clog2(MAX_SIDE + 1);

    logic [7:0] mem [0:DEPTH-1];

    logic [9:0]  r_cfg_w;
    logic [9:0]  r_cfg_h;
    logic [7:0]  r_cfg_bg;

    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_row_base;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [7:0]        r_rdata;

    logic              r_clear;
    logic              r_filled;
    logic [7:0]        r_color;
    logic [1:0]        r_status;
    logic              r_rd_hit;
    logic signed [CW-1:0] r_x_lo, r_x_hi, r_x_lo_in, r_x_hi_in;
    logic signed [CW-1:0] r_y_lo, r_y_hi, r_y_lo_in, r_y_hi_in;
    t_out              r_out;

    logic [SW-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [15:0]   cfg_w16, cfg_h16;
    logic          col_last, row_last;
    logic signed [CW-1:0] fx, fy;
    logic          in_rect, edge_px, mem_we;
    logic [ADDR_W-1:0] scan_addr;
    logic signed [CW-1:0] in_x, in_y, in_w, in_h, in_x2, in_y2;
    logic          size_bad, kind_bad, rd_in_range;
    logic [1:0]    in_status;
    logic [31:0]   rd_addr_full;

    // size registers out of range act as the nearest legal size
    always_comb begin
        cfg_w16 = 16'(r_cfg_w);
        cfg_h16 = 16'(r_cfg_h);
        if (cfg_w16 == 16'd0) begin
            w_eff = SW'(1);
        end else if (cfg_w16 > 16'(MAX_SIDE)) begin
            w_eff = SW'(MAX_SIDE);
        end else begin
            w_eff = SW'(cfg_w16);
        end
        if (cfg_h16 == 16'd0) begin
            h_eff = SW'(1);
        end else if (cfg_h16 > 16'(MAX_SIDE)) begin
            h_eff = SW'(MAX_SIDE);
        end else begin
            h_eff = SW'(cfg_h16);
        end
        w_m1 = w_eff - SW'(1);
        h_m1 = h_eff - SW'(1);
    end

    assign col_last = (SW'(r_col) == w_m1);
    assign row_last = (SW'(r_row) == h_m1);

    // incoming item decode
    always_comb begin
        in_x  = CW'($signed(i_in.rect_x));
        in_y  = CW'($signed(i_in.rect_y));
        in_w  = CW'($signed(i_in.rect_w));
        in_h  = CW'($signed(i_in.rect_h));
        in_x2 = in_x + in_w;
        in_y2 = in_y + in_h;
        size_bad = (in_w <= $signed(CW'(0))) || (in_h <= $signed(CW'(0)));
        kind_bad = (i_in.rect_kind != KIND_OUTLINE) && (i_in.rect_kind != KIND_FILLED);
        rd_in_range = (16'(i_in.pixel_col) < 16'(w_eff)) && (16'(i_in.pixel_row) < 16'(h_eff));
        rd_addr_full = 32'(i_in.pixel_row) * 32'(MAX_SIDE) + 32'(i_in.pixel_col);
        in_status = STAT_OK;
        o_sts.route = RT_DONE;
        o_sts.scan_last = col_last && row_last;
        unique case (i_in.opcode)
            OP_CLEAR: begin
                o_sts.route = RT_SCAN;
            end
            OP_DRAW: begin
                if (size_bad) begin
                    in_status = STAT_SIZE;
                end else if (kind_bad) begin
                    in_status = STAT_KIND;
                end else begin
                    o_sts.route = RT_SCAN;
                end
            end
            OP_READ: begin
                if (rd_in_range) begin
                    o_sts.route = RT_READ;
                end
            end
            default: begin
                o_sts.route = RT_DONE;
            end
        endcase
    end

    // pixel test against bounds latched at load
    always_comb begin
        fx = $signed(CW'({r_col, {FRAC_BITS{1'b0}}}));
        fy = $signed(CW'({r_row, {FRAC_BITS{1'b0}}}));
        in_rect = (fx >= r_x_lo) && (fx <= r_x_hi) && (fy >= r_y_lo) && (fy <= r_y_hi);
        edge_px = (fx < r_x_lo_in) || (fx > r_x_hi_in) || (fy < r_y_lo_in) || (fy > r_y_hi_in);
        mem_we  = i_cmd.scan_step && (r_clear || (in_rect && (edge_px || r_filled)));
        scan_addr = r_row_base + ADDR_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 10'd1;
            r_cfg_h  <= 10'd1;
            r_cfg_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h  <= i_cfg_data;
                CFG_BG:     r_cfg_bg <= i_cfg_data[7:0];
                default:    r_cfg_bg <= r_cfg_bg;
            endcase
        end
    end

    // item registers and scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clear    <= (i_in.opcode == OP_CLEAR);
            r_filled   <= (i_in.rect_kind == KIND_FILLED);
            r_color    <= i_in.paint_char;
            r_status   <= in_status;
            r_rd_hit   <= (i_in.opcode == OP_READ) && rd_in_range;
            r_rd_addr  <= ADDR_W'(rd_addr_full);
            r_x_lo     <= in_x;
            r_x_hi     <= in_x2;
            r_x_lo_in  <= in_x + FRAC_ONE;
            r_x_hi_in  <= in_x2 - FRAC_ONE;
            r_y_lo     <= in_y;
            r_y_hi     <= in_y2;
            r_y_lo_in  <= in_y + FRAC_ONE;
            r_y_hi_in  <= in_y2 - FRAC_ONE;
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (i_cmd.scan_step) begin
            if (col_last) begin
                r_col      <= '0;
                r_row      <= r_row + CNT_W'(1);
                r_row_base <= r_row_base + ADDR_W'(MAX_SIDE);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[scan_addr] <= r_clear ? r_cfg_bg : r_color;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pixel_value <= r_rd_hit ? r_rdata : 8'h00;
            r_out.status      <= r_status;
        end
    end

    assign o_out = r_out;

endmodule

// ===== sv/rcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcr_ctrl
// command sequencer: accept, scan or read as the command needs, then hand the result to the output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcr_ctrl import rcr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.load = 1'b1;
                    unique case (i_sts.route)
                        RT_SCAN: n_state = S_SCAN;
                        RT_READ: n_state = S_READ;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RDATA;
            end
            S_RDATA: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_IMPL(a_load_slot_free, i_clk, i_rst_n, o_cmd.out_load, (!r_out_valid || !i_out_stall), "result loaded over a pending transaction")
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept, (r_state != S_IDLE), "accepted transaction did not start")
    `ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, (r_state == S_SCAN && i_sts.scan_last), (r_state == S_FIN), "scan did not finish on last pixel")

endmodule

// ===== sv/rectangle_canvas_raster.sv =====
// clear and draw scan the canvas; in-range reads pass S_READ and S_RDATA; others go straight to S_FIN
// throughput: one transaction at a time; the canvas scan writes one pixel per cycle
// through the single memory write port
// a finished result may wait in the output register while the next transaction is taken
// reset: synchronous, active low; control and config return to width 1, height 1, bg 0x20
// the canvas memory is not cleared by reset and must be cleared by command before a read
// ----------------------------------------------------------------------------
// rectangle_canvas_raster
// byte canvas with clear, rectangle fill or outline, and pixel read commands
// ----------------------------------------------------------------------------
module rectangle_canvas_raster import rcr_pkg::*; #(
    parameter int MAX_SIDE = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcr_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rectangle canvas raster: a scoreboard keeps its
// own copy of the canvas and the size registers, predicts the answer of every
// accepted command, and compares it with the block's result stream
// ----------------------------------------------------------------------------
module tb import rcr_pkg::*; ();

    localparam int     SIDE        = 512;
    localparam int     HOLD_CYCLES = 300;
    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 12;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [1:0] cfg_idx  = CFG_WIDTH;
    logic [9:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in        in_item  = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_item;

    bit idle_on       = 1'b1;
    bit pressure_go   = 1'b0;
    bit pressure_done = 1'b0;
    int hold_cnt      = 0;
    int burst_cnt     = 0;

    class canvas_scoreboard;
        bit [9:0]  width_reg;
        bit [9:0]  height_reg;
        bit [7:0]  bg_reg;
        bit [7:0]  canvas_mem [SIDE*SIDE];
        t_out      answers [$];
        int        errors;

        function new();
            width_reg  = 10'd1;
            height_reg = 10'd1;
            bg_reg     = BG_RESET;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [9:0] data);
            case (idx)
                CFG_WIDTH:  width_reg  = data;
                CFG_HEIGHT: height_reg = data;
                CFG_BG:     bg_reg     = data[7:0];
                default: ;
            endcase
        endfunction

        // size register as the block uses it: 0 acts as 1, above the maximum clamps
        function int side_of(bit [9:0] v);
            if (v == 0)
                return 1;
            if (v > SIDE)
                return SIDE;
            return int'(v);
        endfunction

        function int cols();
            return side_of(width_reg);
        endfunction

        function int rows();
            return side_of(height_reg);
        endfunction

        function void note_command(t_in cmd);
            int     ncol, nrow, r, c;
            longint x0, y0, x1, y1, fx, fy;
            bit     border;
            t_out   ans;
            ncol = cols();
            nrow = rows();
            ans  = '0;
            case (cmd.opcode)
                OP_CLEAR: begin
                    for (r = 0; r < nrow; r++)
                        for (c = 0; c < ncol; c++)
                            canvas_mem[r*SIDE + c] = bg_reg;
                end
                OP_DRAW: begin
                    if ($signed(cmd.rect_w) <= 0 || $signed(cmd.rect_h) <= 0) begin
                        ans.status = STAT_SIZE;
                    end else if (cmd.rect_kind != KIND_OUTLINE &&
                                 cmd.rect_kind != KIND_FILLED) begin
                        ans.status = STAT_KIND;
                    end else begin
                        x0 = longint'($signed(cmd.rect_x));
                        y0 = longint'($signed(cmd.rect_y));
                        x1 = x0 + longint'($signed(cmd.rect_w));
                        y1 = y0 + longint'($signed(cmd.rect_h));
                        for (r = 0; r < nrow; r++) begin
                            fy = longint'(r) * 256;
                            if (fy < y0 || fy > y1)
                                continue;
                            for (c = 0; c < ncol; c++) begin
                                fx = longint'(c) * 256;
                                if (fx < x0 || fx > x1)
                                    continue;
                                border = (fx - x0 < 256) || (fy - y0 < 256) ||
                                         (x1 - fx < 256) || (y1 - fy < 256);
                                if (border || cmd.rect_kind == KIND_FILLED)
                                    canvas_mem[r*SIDE + c] = cmd.paint_char;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (cmd.pixel_col < ncol && cmd.pixel_row < nrow)
                        ans.pixel_value = canvas_mem[cmd.pixel_row*SIDE + cmd.pixel_col];
                end
                default: ;
            endcase
            answers.push_back(ans);
        endfunction

        function void check_answer(t_out got);
            t_out want;
            if (answers.size() == 0) begin
                $error("result with no command waiting: pixel_value %0h status %0d",
                       got.pixel_value, got.status);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got.pixel_value !== want.pixel_value) begin
                $error("pixel_value mismatch: expected %0h, actual %0h",
                       want.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    canvas_scoreboard sb = new();

    rectangle_canvas_raster DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #1 i_clk = ~i_clk;

    // receiver stall: one long hold-off on request, otherwise random bursts while idle_on is set
    always @(negedge i_clk) begin
        if (pressure_go && !pressure_done) begin
            hold_cnt      = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else if (burst_cnt > 0) begin
            burst_cnt--;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst_cnt = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_answer(out_item);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_in any_command();
        t_in cmd;
        cmd.opcode     = 2'($urandom_range(0, 3));
        cmd.rect_x     = 24'($urandom);
        cmd.rect_y     = 24'($urandom);
        cmd.rect_w     = 24'($urandom);
        cmd.rect_h     = 24'($urandom);
        cmd.rect_kind  = 8'($urandom);
        cmd.paint_char = 8'($urandom);
        cmd.pixel_col  = 9'($urandom);
        cmd.pixel_row  = 9'($urandom);
        return cmd;
    endfunction

    function automatic t_in clear_cmd();
        t_in cmd;
        cmd        = any_command();
        cmd.opcode = OP_CLEAR;
        return cmd;
    endfunction

    function automatic t_in draw_cmd(int x, int y, int w, int h,
                                     logic [7:0] kind, logic [7:0] color);
        t_in cmd;
        cmd            = any_command();
        cmd.opcode     = OP_DRAW;
        cmd.rect_x     = 24'(x);
        cmd.rect_y     = 24'(y);
        cmd.rect_w     = 24'(w);
        cmd.rect_h     = 24'(h);
        cmd.rect_kind  = kind;
        cmd.paint_char = color;
        return cmd;
    endfunction

    function automatic t_in read_cmd(int c, int r);
        t_in cmd;
        cmd           = any_command();
        cmd.opcode    = OP_READ;
        cmd.pixel_col = 9'(c);
        cmd.pixel_row = 9'(r);
        return cmd;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_command(input t_in cmd);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= cmd;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        sb.note_command(cmd);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.answers.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // registers change only once every answer is back and the block is idle
    task automatic configure(input logic [9:0] w, input logic [9:0] h, input logic [9:0] bg);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= w;
        sb.write_reg(CFG_WIDTH, w);
        @(negedge i_clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= h;
        sb.write_reg(CFG_HEIGHT, h);
        @(negedge i_clk);
        cfg_idx  <= CFG_BG;
        cfg_data <= bg;
        sb.write_reg(CFG_BG, bg);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int         ncol, nrow, pick, x, y, w, h, i;
        logic [7:0] kind;
        t_in        cmd;
        ncol = sb.cols();
        nrow = sb.rows();
        // every phase starts with a clear so no read hits an unwritten pixel
        send_command(clear_cmd());
        for (i = 1; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                x = int'($urandom_range(0, (ncol + 2) * 256)) - 512;
                y = int'($urandom_range(0, (nrow + 2) * 256)) - 512;
                w = $urandom_range(1, (ncol + 2) * 256);
                h = $urandom_range(1, (nrow + 2) * 256);
                if ($urandom_range(0, 1) == 0) begin
                    // whole-pixel edges land exactly on pixel centers
                    x = x & ~32'hFF;
                    y = y & ~32'hFF;
                    w = (w & ~32'hFF) | 32'h100;
                    h = (h & ~32'hFF) | 32'h100;
                end
                if (pick < 36)
                    kind = $urandom_range(0, 1) ? KIND_OUTLINE : KIND_FILLED;
                else
                    kind = 8'($urandom);
                cmd = draw_cmd(x, y, w, h, kind, 8'($urandom));
            end else if (pick < 75) begin
                cmd = read_cmd($urandom_range(0, ncol - 1), $urandom_range(0, nrow - 1));
            end else if (pick < 82) begin
                cmd = read_cmd($urandom_range(0, 511), $urandom_range(0, 511));
            end else if (pick < 88) begin
                cmd = clear_cmd();
            end else begin
                cmd = any_command();
            end
            send_command(cmd);
        end
    endtask

    initial begin
        int p;
        t_in cmd;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes: a single pixel
        send_command(clear_cmd());
        send_command(read_cmd(0, 0));
        send_command(read_cmd(511, 511));
        cmd        = any_command();
        cmd.opcode = OP_NOP;
        send_command(cmd);

        configure(10'd8, 10'd6, 10'd255);
        send_command(clear_cmd());
        send_command(draw_cmd(256, 256, 768, 512, KIND_FILLED, 8'h41));
        // fractional outline partly off the top of the canvas
        send_command(draw_cmd(128, -128, 6*256 + 77, 4*256, KIND_OUTLINE, 8'h62));
        send_command(draw_cmd(0, 0, 0, 256, KIND_FILLED, 8'h78));
        send_command(draw_cmd(0, 0, 256, -1, KIND_OUTLINE, 8'h78));
        send_command(draw_cmd(0, 0, 256, 256, 8'h51, 8'h78));
        // bad size and bad kind together
        send_command(draw_cmd(0, 0, -8388608, 256, 8'h00, 8'h78));
        send_command(draw_cmd(-8388608, -8388608, 8388607, 8388607, KIND_FILLED, 8'h00));
        send_command(draw_cmd(8388607, 8388607, 1, 1, KIND_FILLED, 8'hFF));
        send_command(read_cmd(0, 0));
        send_command(read_cmd(2, 2));
        send_command(read_cmd(7, 5));
        send_command(read_cmd(8, 0));

        // width 0 acts as 1, height above the maximum clamps
        configure(10'd0, 10'd1023, 10'd0);
        send_command(clear_cmd());
        send_command(read_cmd(0, 511));

        configure(10'd512, 10'd1, 10'h2E);
        send_command(clear_cmd());
        send_command(read_cmd(511, 0));

        configure(10'd512, 10'd512, 10'h55);
        send_command(clear_cmd());
        send_command(draw_cmd(0, 0, 511*256, 511*256, KIND_OUTLINE, 8'h23));
        send_command(read_cmd(511, 511));
        send_command(read_cmd(256, 256));

        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 1) begin
                // tiny canvas, no sender gaps: a long output hold-off backs up the input
                configure(10'd1, 10'd1, 10'($urandom_range(0, 255)));
                idle_on     = 1'b0;
                pressure_go = 1'b1;
            end else begin
                configure(10'($urandom_range(1, 24)), 10'($urandom_range(1, 24)),
                          10'($urandom_range(0, 1023)));
                idle_on = (p < RAND_PHASES - 2) && (p % 2 == 0);
            end
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
